// File: rtl/grid_ray_march_fan_top_assert.svh
// Assertion macros for the grid ray-march fan checker.
`ifndef GRID_RAY_MARCH_FAN_TOP_ASSERT_SVH
`define GRID_RAY_MARCH_FAN_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define GRMF_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("grmf check failed: same-cycle rule");

// Next-cycle implication, sampled on clk, off during rst.
`define GRMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("grmf check failed: next-cycle rule");

`endif

// File: rtl/grmf_pkg.sv
// Package: constants, types and trig table for the grid ray-march fan.
`timescale 1ns / 1ps

package grmf_pkg;

  localparam int GRID_SIZE  = 32;
  localparam int STEP_LIMIT = 1023;
  localparam int ADDR_W     = $clog2(GRID_SIZE);
  localparam int MAP_CELLS  = (GRID_SIZE >= 32) ? 32 : GRID_SIZE;
  localparam int MAP_LIMIT  = MAP_CELLS * 2048;

  localparam int POS_W  = 16;
  localparam int FRAC_W = 11;
  localparam int NPOS_W = POS_W + 2;
  localparam int STEP_W = 11;
  localparam int TRIG_W = 15;
  localparam int PROD_W = STEP_W + TRIG_W;
  localparam int MAG_W  = 11;
  localparam int VEC_W  = MAG_W + 1;

  localparam int STEPS_W       = $clog2(STEP_LIMIT + 1);
  localparam int STEPS_OUT_W   = 10;
  localparam int STEPS_OUT_MAX = 1023;

  localparam int RAY_COUNT = 46;
  localparam int RAY_W     = 6;
  localparam int RAY_DELTA = 32;

  localparam int FULL_TURN = 5760;
  localparam int QUARTER   = 1440;
  localparam int EIGHTH    = 720;
  localparam int HEAD_W    = 13;
  localparam int ANG_W     = 13;
  localparam int REM_W     = 11;
  localparam int TAB_DEPTH = QUARTER + 1;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  localparam longint unsigned PI_Q30 = 64'hC90FDAA2;

  // Series divisors (2k-1)(2k) for cos and (2k)(2k+1) for sin, k = 1..12
  localparam longint unsigned COS_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };
  localparam longint unsigned SIN_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam int STEP_RESET = 205;

  // Input item layout
  localparam int IN_ROW_W      = 5;
  localparam int IN_CELLS_W    = 32;
  localparam int IN_ROW_LSB    = 0;
  localparam int IN_CELLS_LSB  = IN_ROW_LSB + IN_ROW_W;
  localparam int IN_SX_LSB     = IN_CELLS_LSB + IN_CELLS_W;
  localparam int IN_SY_LSB     = IN_SX_LSB + POS_W;
  localparam int IN_HEAD_LSB   = IN_SY_LSB + POS_W;
  localparam int IN_USED_W     = IN_HEAD_LSB + HEAD_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output item layout
  localparam int OUTCOME_W       = 2;
  localparam int OUT_RAY_LSB     = 0;
  localparam int OUT_X_LSB       = OUT_RAY_LSB + RAY_W;
  localparam int OUT_Y_LSB       = OUT_X_LSB + POS_W;
  localparam int OUT_OUTCOME_LSB = OUT_Y_LSB + POS_W;
  localparam int OUT_STEPS_LSB   = OUT_OUTCOME_LSB + OUTCOME_W;
  localparam int OUT_USED_W      = OUT_STEPS_LSB + STEPS_OUT_W;
  localparam int OUT_TDATA_W     = ((OUT_USED_W + 7) / 8) * 8;

  localparam logic ACT_ROW_WRITE = 1'b0;
  localparam logic ACT_CAST      = 1'b1;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_HIT   = 2'd0,
    OUT_LEFT  = 2'd1,
    OUT_LIMIT = 2'd2
  } outcome_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG_A,
    ST_TRIG_B,
    ST_TRIG_C,
    ST_TRIG_D,
    ST_GRID_RD,
    ST_MARCH,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic row_wr;
    logic cap_cast;
    logic rom_sin;
    logic mul_load;
    logic round_c;
    logic set_vec;
    logic march_step;
    logic load_out;
    logic next_ray;
  } cmd_t;

  typedef struct packed {
    logic start_out;
    logic march_done;
    logic last_ray;
    logic out_free;
  } stat_t;

  typedef logic [TRIG_W-1:0] trig_tab_t [TAB_DEPTH];

  // Q1.14 cos or sin of a 0..720 sixteenth-degree angle, series in Q.30
  function automatic logic [TRIG_W-1:0] octant_trig(int a, bit want_sin);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint sm;
    x = (longint'(unsigned'(a)) * PI_Q30) / (FULL_TURN / 2);
    x2 = (x * x) >> 30;
    term = want_sin ? x : (64'd1 << 30);
    sm = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      if (want_sin) begin
        term = ((term * x2) >> 30) / SIN_DIV[k - 1];
      end else begin
        term = ((term * x2) >> 30) / COS_DIV[k - 1];
      end
      if ((k % 2) == 1) begin
        sm = sm - longint'(term);
      end else begin
        sm = sm + longint'(term);
      end
    end
    if (sm < 0) begin
      sm = 0;
    end
    sm = (sm + 32768) >>> 16;
    if (sm > 16384) begin
      sm = 16384;
    end
    return TRIG_W'(sm);
  endfunction

  // Entry i: cos series of i up to an eighth, sin series of the rest past it
  function automatic trig_tab_t build_trig_tab();
    trig_tab_t tab;
    for (int i = 0; i < TAB_DEPTH; i++) begin
      if (i <= EIGHTH) begin
        tab[i] = octant_trig(i, 1'b0);
      end else begin
        tab[i] = octant_trig(QUARTER - i, 1'b1);
      end
    end
    return tab;
  endfunction

  localparam trig_tab_t TRIG_TAB = build_trig_tab();

  // round(p / 2^14) of a nonnegative product
  function automatic logic [MAG_W-1:0] round_q14(logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + PROD_W'(8192);
    return MAG_W'(s >> 14);
  endfunction

endpackage

// File: rtl/grmf_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module grmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/grmf_ctrl.sv
// Controller: sequences trig setup, march steps and result hand-off per ray.
`timescale 1ns / 1ps

module grmf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_action,
  output logic            in_ready,
  input  grmf_pkg::stat_t stat,
  output grmf_pkg::cmd_t  cmd
);

  import grmf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_action == ACT_CAST) begin
          state_next = ST_TRIG_A;
        end
      end
      ST_TRIG_A: state_next = ST_TRIG_B;
      ST_TRIG_B: state_next = ST_TRIG_C;
      ST_TRIG_C: state_next = ST_TRIG_D;
      ST_TRIG_D: begin
        state_next = stat.start_out ? ST_EMIT : ST_GRID_RD;
      end
      ST_GRID_RD: state_next = ST_MARCH;
      ST_MARCH: begin
        state_next = stat.march_done ? ST_EMIT : ST_GRID_RD;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = stat.last_ray ? ST_IDLE : ST_TRIG_A;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.row_wr   = in_valid && in_action == ACT_ROW_WRITE;
        cmd.cap_cast = in_valid && in_action == ACT_CAST;
      end
      ST_TRIG_A: begin
      end
      ST_TRIG_B: begin
        cmd.mul_load = 1'b1;
        cmd.rom_sin  = 1'b1;
      end
      ST_TRIG_C: begin
        cmd.mul_load = 1'b1;
        cmd.round_c  = 1'b1;
      end
      ST_TRIG_D: begin
        cmd.set_vec = 1'b1;
      end
      ST_GRID_RD: begin
      end
      ST_MARCH: begin
        cmd.march_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_out = stat.out_free;
        cmd.next_ray = stat.out_free && !stat.last_ray;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: rtl/grmf_dpath.sv
// Datapath: grid store, trig table, step vector, march position and result register.
`timescale 1ns / 1ps

module grmf_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  grmf_pkg::cmd_t                    cmd,
  output grmf_pkg::stat_t                   stat,
  input  logic                              cfg_wr_en,
  input  logic [grmf_pkg::STEP_W-1:0]       cfg_wr_data,
  input  logic [grmf_pkg::IN_TDATA_W-1:0]   in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [grmf_pkg::OUT_TDATA_W-1:0]  out_data,
  output logic                              out_last
);

  import grmf_pkg::*;

  logic [STEP_W-1:0]        step_length;
  logic [GRID_SIZE-1:0]     row_valid;
  logic                     rd_valid;
  logic [GRID_SIZE-1:0]     rd_row;
  logic [ADDR_W-1:0]        grid_raddr;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     wr_ok;

  logic [IN_ROW_W-1:0]      in_row;
  logic [IN_CELLS_W-1:0]    in_cells;
  logic [POS_W-1:0]         in_sx;
  logic [POS_W-1:0]         in_sy;
  logic [HEAD_W-1:0]        in_head;
  logic [HEAD_W:0]          head_mod;
  logic [HEAD_W:0]          ang_sum;

  logic [ANG_W-1:0]         ang;
  logic [ANG_W:0]           ang_inc;
  logic [RAY_W-1:0]         ray;
  logic [1:0]               quad;
  logic [REM_W-1:0]         rem;
  logic [TAB_AW-1:0]        rom_addr;
  logic [TRIG_W-1:0]        rom_q;
  logic [PROD_W-1:0]        prod;
  logic [MAG_W-1:0]         mag_c;
  logic [MAG_W-1:0]         mag_s;
  logic signed [VEC_W-1:0]  pc;
  logic signed [VEC_W-1:0]  ps;
  logic signed [VEC_W-1:0]  dx_new;
  logic signed [VEC_W-1:0]  dy_new;
  logic signed [VEC_W-1:0]  dx;
  logic signed [VEC_W-1:0]  dy;

  logic [POS_W-1:0]         sx;
  logic [POS_W-1:0]         sy;
  logic [POS_W-1:0]         x;
  logic [POS_W-1:0]         y;
  logic signed [NPOS_W-1:0] nx;
  logic signed [NPOS_W-1:0] ny;
  logic                     next_in;
  logic                     wall;
  logic                     at_limit;
  logic [STEPS_W-1:0]       steps;
  outcome_t                 outcome;
  logic [STEPS_OUT_W-1:0]   steps_out;

  assign in_row   = in_data[IN_ROW_LSB +: IN_ROW_W];
  assign in_cells = in_data[IN_CELLS_LSB +: IN_CELLS_W];
  assign in_sx    = in_data[IN_SX_LSB +: POS_W];
  assign in_sy    = in_data[IN_SY_LSB +: POS_W];
  assign in_head  = in_data[IN_HEAD_LSB +: HEAD_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_length <= STEP_W'(STEP_RESET);
    end else if (cfg_wr_en) begin
      step_length <= cfg_wr_data;
    end
  end

  // Grid rows
  assign wr_ok      = 32'(in_row) < 32'(GRID_SIZE);
  assign wr_addr    = ADDR_W'(in_row);
  assign grid_raddr = ADDR_W'(x[POS_W-1:FRAC_W]);

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.row_wr && wr_ok) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_valid <= row_valid[grid_raddr];
  end

  grmf_ram #(
    .WIDTH (GRID_SIZE),
    .DEPTH (GRID_SIZE)
  ) u_grid (
    .clk   (clk),
    .we    (cmd.row_wr && wr_ok),
    .waddr (wr_addr),
    .wdata (GRID_SIZE'(in_cells)),
    .raddr (grid_raddr),
    .rdata (rd_row)
  );

  // Fan angle
  always_comb begin
    head_mod = {1'b0, in_head};
    if (head_mod >= (HEAD_W + 1)'(FULL_TURN)) begin
      head_mod = head_mod - (HEAD_W + 1)'(FULL_TURN);
    end
    ang_sum = head_mod + (HEAD_W + 1)'(FULL_TURN - EIGHTH);
    if (ang_sum >= (HEAD_W + 1)'(FULL_TURN)) begin
      ang_sum = ang_sum - (HEAD_W + 1)'(FULL_TURN);
    end
    ang_inc = {1'b0, ang} + (ANG_W + 1)'(RAY_DELTA);
    if (ang_inc >= (ANG_W + 1)'(FULL_TURN)) begin
      ang_inc = ang_inc - (ANG_W + 1)'(FULL_TURN);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_cast) begin
      ang <= ANG_W'(ang_sum);
      sx  <= in_sx;
      sy  <= in_sy;
    end else if (cmd.next_ray) begin
      ang <= ANG_W'(ang_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ray <= '0;
    end else if (cmd.cap_cast) begin
      ray <= '0;
    end else if (cmd.next_ray) begin
      ray <= ray + RAY_W'(1);
    end
  end

  always_comb begin
    priority if (ang >= ANG_W'(3 * QUARTER)) begin
      quad = 2'd3;
      rem  = REM_W'(ang - ANG_W'(3 * QUARTER));
    end else if (ang >= ANG_W'(2 * QUARTER)) begin
      quad = 2'd2;
      rem  = REM_W'(ang - ANG_W'(2 * QUARTER));
    end else if (ang >= ANG_W'(QUARTER)) begin
      quad = 2'd1;
      rem  = REM_W'(ang - ANG_W'(QUARTER));
    end else begin
      quad = 2'd0;
      rem  = REM_W'(ang);
    end
  end

  assign rom_addr = cmd.rom_sin ? TAB_AW'(REM_W'(QUARTER) - rem) : TAB_AW'(rem);

  always_ff @(posedge clk) begin
    rom_q <= TRIG_TAB[rom_addr];
    if (cmd.mul_load) begin
      prod <= PROD_W'(step_length) * PROD_W'(rom_q);
    end
    if (cmd.round_c) begin
      mag_c <= round_q14(prod);
    end
  end

  assign mag_s = round_q14(prod);
  assign pc    = $signed({1'b0, mag_c});
  assign ps    = $signed({1'b0, mag_s});

  always_comb begin
    unique case (quad)
      2'd0: begin
        dx_new = pc;
        dy_new = ps;
      end
      2'd1: begin
        dx_new = -ps;
        dy_new = pc;
      end
      2'd2: begin
        dx_new = -pc;
        dy_new = -ps;
      end
      2'd3: begin
        dx_new = ps;
        dy_new = -pc;
      end
      default: begin
        dx_new = pc;
        dy_new = ps;
      end
    endcase
  end

  // March
  assign nx = $signed({2'b00, x}) + $signed({{(NPOS_W - VEC_W){dx[VEC_W-1]}}, dx});
  assign ny = $signed({2'b00, y}) + $signed({{(NPOS_W - VEC_W){dy[VEC_W-1]}}, dy});
  assign next_in = !nx[NPOS_W-1] && !ny[NPOS_W-1]
                && (unsigned'(nx) < NPOS_W'(MAP_LIMIT))
                && (unsigned'(ny) < NPOS_W'(MAP_LIMIT));
  assign wall     = rd_valid && rd_row[ADDR_W'(y[POS_W-1:FRAC_W])];
  assign at_limit = 32'(steps) >= 32'(STEP_LIMIT);

  always_ff @(posedge clk) begin
    if (cmd.set_vec) begin
      dx      <= dx_new;
      dy      <= dy_new;
      x       <= sx;
      y       <= sy;
      steps   <= '0;
      outcome <= OUT_LEFT;
    end else if (cmd.march_step) begin
      priority if (wall) begin
        outcome <= OUT_HIT;
      end else if (at_limit) begin
        outcome <= OUT_LIMIT;
      end else if (!next_in) begin
        outcome <= OUT_LEFT;
      end else begin
        x     <= POS_W'(unsigned'(nx));
        y     <= POS_W'(unsigned'(ny));
        steps <= steps + STEPS_W'(1);
      end
    end
  end

  assign stat.start_out  = !(({1'b0, sx} < (POS_W + 1)'(MAP_LIMIT))
                          && ({1'b0, sy} < (POS_W + 1)'(MAP_LIMIT)));
  assign stat.march_done = wall || at_limit || !next_in;
  assign stat.last_ray   = ray == RAY_W'(RAY_COUNT - 1);
  assign stat.out_free   = !out_valid || out_ready;

  assign steps_out = (32'(steps) > 32'(STEPS_OUT_MAX)) ? STEPS_OUT_W'(STEPS_OUT_MAX)
                                                      : STEPS_OUT_W'(steps);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= OUT_TDATA_W'({steps_out, outcome, y, x, ray});
      out_last <= stat.last_ray;
    end
  end

endmodule

// File: rtl/grid_ray_march_fan_top.sv
// Top level of the grid ray-march fan: controller, datapath and ports.
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | row write or cast item, action in tuser
//  m_axis   | m_axis_tvalid/m_axis_tready | one ray result, tlast on ray 45
//  cfg      | cfg_wr_en                   | step_length, written while cfg_wr_en is high
//
// A row write is taken straight from the idle state. A cast marches 46 rays in turn:
// per ray, the trig table read and rounding states, then a grid read state and a
// march state for each march step and for the final test, set by the single
// registered read port of the grid memory, and a hand-off state.
// Reset empties the grid at once (row valid bits) and loads step_length with 205.
// A waiting result sits in the output register; a finished ray holds in its
// hand-off state until that register frees, and only then does the next ray start.
`timescale 1ns / 1ps

module grid_ray_march_fan_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // row_number[4:0], row_cells[36:5], start_x[52:37], start_y[68:53], heading[81:69]
  input  logic [grmf_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // action[0]
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // ray_number[5:0], end_x[21:6], end_y[37:22], outcome[39:38], steps_taken[49:40]
  output logic [grmf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // final_ray
  output logic                              m_axis_tlast,
  input  logic                              cfg_wr_en,
  input  logic [grmf_pkg::STEP_W-1:0]       cfg_wr_data
);

  import grmf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  grmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  grmf_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_axis_tdata),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_data    (m_axis_tdata),
    .out_last    (m_axis_tlast)
  );

endmodule

// File: rtl/grmf_checker.sv
// Port-level checker for the grid ray-march fan, bound to the top level.
`timescale 1ns / 1ps
`include "grid_ray_march_fan_top_assert.svh"

module grmf_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [grmf_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);

  import grmf_pkg::*;

  logic [RAY_W-1:0]     out_ray;
  logic [OUTCOME_W-1:0] out_code;
  logic                 cast_taken;

  assign out_ray    = m_axis_tdata[OUT_RAY_LSB +: RAY_W];
  assign out_code   = m_axis_tdata[OUT_OUTCOME_LSB +: OUTCOME_W];
  assign cast_taken = s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_CAST;

  `GRMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `GRMF_ASSERT_NEXT(a_cast_busy, cast_taken, !s_axis_tready)
  `GRMF_ASSERT_IMPLIES(a_last_ray, m_axis_tvalid, m_axis_tlast == (out_ray == RAY_W'(RAY_COUNT - 1)))
  `GRMF_ASSERT_IMPLIES(a_outcome, m_axis_tvalid, out_code == OUT_HIT || out_code == OUT_LEFT || out_code == OUT_LIMIT)

endmodule

bind grid_ray_march_fan_top grmf_checker u_grmf_checker (.*);

// File: dv/grid_ray_march_fan_checker.sv
`timescale 1ns / 1ps
// Checker for the grid ray-march fan: predicts each fan of ray results and compares them.
module grid_ray_march_fan_checker
  import grmf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tuser,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   m_axis_tlast,
  input  logic                   cfg_wr_en,
  input  logic [STEP_W-1:0]      cfg_wr_data,
  output int                     fail_count,
  output int                     open_rays
);

  typedef struct packed {
    logic [RAY_W-1:0]       ray;
    logic [POS_W-1:0]       end_x;
    logic [POS_W-1:0]       end_y;
    outcome_t               outcome;
    logic [STEPS_OUT_W-1:0] steps;
    logic                   last;
  } ray_result_t;

  logic [GRID_SIZE-1:0] walls [GRID_SIZE];
  logic [STEP_W-1:0]    step_len;
  ray_result_t          pending_rays [$];
  int                   errs = 0;

  // Q1.14 cos (even series) or sin (odd series) of 0..720 sixteenths of a degree
  function automatic int trig_q14(int unsigned a, bit want_sin);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint          acc;
    x = (64'(a) * PI_Q30) / 64'(FULL_TURN / 2);
    x2 = (x * x) >> 30;
    term = want_sin ? x : (64'd1 << 30);
    acc = longint'(term);
    for (int k = 1; k <= 12; k++) begin
      dv = want_sin ? 64'(2 * k * (2 * k + 1)) : 64'((2 * k - 1) * 2 * k);
      term = ((term * x2) >> 30) / dv;
      if (k % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) begin
      acc = 16384;
    end
    return int'(acc);
  endfunction

  // round(step_len * t / 2^14), ties away from zero
  function automatic int scaled_step(int t);
    longint p;
    longint m;
    p = longint'(step_len) * longint'(t);
    m = (p < 0) ? -p : p;
    m = (m + 8192) >>> 14;
    return int'((p < 0) ? -m : m);
  endfunction

  function automatic bit on_map(int x, int y);
    return x >= 0 && y >= 0 && x < MAP_LIMIT && y < MAP_LIMIT;
  endfunction

  function automatic void march_fan(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                                    logic [HEAD_W-1:0] head);
    int unsigned h;
    int unsigned ang;
    int unsigned r;
    int          cr, sr, c, s, dx, dy, x, y, n;
    outcome_t    oc;
    bit          done;
    bit          blocked;
    ray_result_t res;
    h = head % FULL_TURN;
    for (int ray = 0; ray < RAY_COUNT; ray++) begin
      ang = (h + FULL_TURN - EIGHTH + RAY_DELTA * ray) % FULL_TURN;
      r = ang % QUARTER;
      if (r <= EIGHTH) begin
        cr = trig_q14(r, 1'b0);
        sr = trig_q14(r, 1'b1);
      end else begin
        cr = trig_q14(QUARTER - r, 1'b1);
        sr = trig_q14(QUARTER - r, 1'b0);
      end
      case (ang / QUARTER)
        0: begin
          c = cr;
          s = sr;
        end
        1: begin
          c = -sr;
          s = cr;
        end
        2: begin
          c = -cr;
          s = -sr;
        end
        default: begin
          c = sr;
          s = -cr;
        end
      endcase
      dx = scaled_step(c);
      dy = scaled_step(s);
      x = int'(sx);
      y = int'(sy);
      n = 0;
      oc = OUT_LEFT;
      done = !on_map(x, y);
      while (!done) begin
        blocked = ((x >>> FRAC_W) < GRID_SIZE) && ((y >>> FRAC_W) < GRID_SIZE) &&
                  walls[x >>> FRAC_W][y >>> FRAC_W];
        if (blocked) begin
          oc = OUT_HIT;
          done = 1'b1;
        end else if (n >= STEP_LIMIT) begin
          oc = OUT_LIMIT;
          done = 1'b1;
        end else if (!on_map(x + dx, y + dy)) begin
          oc = OUT_LEFT;
          done = 1'b1;
        end else begin
          x = x + dx;
          y = y + dy;
          n++;
        end
      end
      res.ray = RAY_W'(ray);
      res.end_x = POS_W'(x);
      res.end_y = POS_W'(y);
      res.outcome = oc;
      res.steps = (n > STEPS_OUT_MAX) ? STEPS_OUT_W'(STEPS_OUT_MAX) : STEPS_OUT_W'(n);
      res.last = (ray == RAY_COUNT - 1);
      pending_rays.push_back(res);
    end
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    ray_result_t want;
    if (rst) begin
      foreach (walls[i]) walls[i] = '0;
      step_len = STEP_W'(STEP_RESET);
      pending_rays.delete();
    end else begin
      if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
        if (pending_rays.size() == 0) begin
          $error("ray result with none pending: tdata %h", m_axis_tdata);
          errs++;
        end else begin
          want = pending_rays.pop_front();
          check_field("ray_number", 16'(want.ray), 16'(m_axis_tdata[OUT_RAY_LSB +: RAY_W]));
          check_field("end_x", want.end_x, m_axis_tdata[OUT_X_LSB +: POS_W]);
          check_field("end_y", want.end_y, m_axis_tdata[OUT_Y_LSB +: POS_W]);
          check_field("outcome", 16'(want.outcome),
                      16'(m_axis_tdata[OUT_OUTCOME_LSB +: OUTCOME_W]));
          check_field("steps_taken", 16'(want.steps),
                      16'(m_axis_tdata[OUT_STEPS_LSB +: STEPS_OUT_W]));
          check_field("final_ray", 16'(want.last), 16'(m_axis_tlast));
        end
      end
      if (cfg_wr_en) begin
        step_len = cfg_wr_data;
      end
      if (s_axis_tvalid && s_axis_tready === 1'b1) begin
        if (s_axis_tuser == ACT_CAST) begin
          march_fan(s_axis_tdata[IN_SX_LSB +: POS_W], s_axis_tdata[IN_SY_LSB +: POS_W],
                    s_axis_tdata[IN_HEAD_LSB +: HEAD_W]);
        end else if (int'(s_axis_tdata[IN_ROW_LSB +: IN_ROW_W]) < GRID_SIZE) begin
          walls[s_axis_tdata[IN_ROW_LSB +: IN_ROW_W]] =
            GRID_SIZE'(s_axis_tdata[IN_CELLS_LSB +: IN_CELLS_W]);
        end
      end
    end
    open_rays <= pending_rays.size();
    fail_count <= errs;
  end

endmodule

// File: dv/grid_ray_march_fan_top_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives grid rows, fan casts and step lengths, and reports the verdict.
module grid_ray_march_fan_top_tb;
  import grmf_pkg::*;

  localparam int HOLD_AT     = 70;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE      = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = ACT_ROW_WRITE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_wr_en = 1'b0;
  logic [STEP_W-1:0]      cfg_wr_data = '0;
  int                     fail_count;
  int                     open_rays;
  int                     rows_sent = 0;
  int                     casts_sent = 0;
  int                     step_writes = 0;
  int                     rays_taken = 0;
  bit                     send_burst = 1'b0;

  always #1 clk = ~clk;

  grid_ray_march_fan_top u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  grid_ray_march_fan_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .fail_count    (fail_count),
    .open_rays     (open_rays)
  );

  task automatic send_item(logic act, logic [IN_ROW_W-1:0] row, logic [IN_CELLS_W-1:0] cells,
                           logic [POS_W-1:0] sx, logic [POS_W-1:0] sy,
                           logic [HEAD_W-1:0] head);
    logic [IN_TDATA_W-1:0] d;
    int                    gap;
    gap = send_burst ? 0 : $urandom_range(0, 19);
    d = '0;
    d[IN_ROW_LSB +: IN_ROW_W] = row;
    d[IN_CELLS_LSB +: IN_CELLS_W] = cells;
    d[IN_SX_LSB +: POS_W] = sx;
    d[IN_SY_LSB +: POS_W] = sy;
    d[IN_HEAD_LSB +: HEAD_W] = head;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    s_axis_tuser <= act;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    if (act == ACT_CAST) begin
      casts_sent++;
    end else begin
      rows_sent++;
    end
  endtask

  task automatic load_row(logic [IN_ROW_W-1:0] row, logic [IN_CELLS_W-1:0] cells);
    send_item(ACT_ROW_WRITE, row, cells, POS_W'($urandom), POS_W'($urandom),
              HEAD_W'($urandom));
  endtask

  task automatic cast_from(logic [POS_W-1:0] sx, logic [POS_W-1:0] sy, logic [HEAD_W-1:0] head);
    send_item(ACT_CAST, IN_ROW_W'($urandom), $urandom, sx, sy, head);
  endtask

  // drop valid, wait for every pending ray, then let any row write finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (open_rays != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_step(logic [STEP_W-1:0] v);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_writes++;
  endtask

  initial begin : receiver
    bit take_burst;
    int gap;
    take_burst = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (rays_taken == HOLD_AT) begin
        gap = HOLD_CYCLES;
      end else if (take_burst) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 19);
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      rays_taken++;
      if (rays_taken % 40 == 0) begin
        take_burst = ($urandom_range(0, 2) == 0);
      end
    end
  end

  initial begin : stimulus
    int                    n_rows;
    int                    n_casts;
    int                    random_items;
    logic [STEP_W-1:0]     step;
    logic [IN_CELLS_W-1:0] cells;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    cast_from(16'h8000, 16'h8000, 13'd0);
    load_row(5'd0, '1);
    load_row(5'd31, '1);
    load_row(5'd16, 32'h0001_0000);
    cast_from(16'h8400, 16'h8400, HEAD_W'($urandom));
    cast_from(16'h0000, 16'h0000, 13'd2880);
    load_row(5'd31, '0);
    cast_from(16'hFFFF, 16'hFFFF, 13'd720);
    set_step(11'd2047);
    cast_from(16'h4000, 16'hC000, 13'h1FFF);
    cast_from(16'h7C00, 16'h2000, 13'd5759);
    set_step(11'd1024);
    cast_from(16'h3000, 16'h3000, 13'd4320);
    // crawl beside the wall cell: some rays hit, the rest run to the step limit
    set_step(11'd1);
    cast_from(16'h8000 - 16'd100, 16'h8400, 13'd1440);

    set_step(11'd300);
    random_items = 0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      load_row(IN_ROW_W'(r), $urandom | $urandom);
      random_items++;
    end
    while (random_items < 85) begin
      case ($urandom_range(0, 4))
        0: step = 11'd2047;
        1: step = STEP_W'(STEP_RESET);
        default: step = STEP_W'($urandom_range(120, 2047));
      endcase
      set_step(step);
      send_burst = ($urandom_range(0, 3) == 0);
      n_rows = $urandom_range(2, 6);
      n_casts = $urandom_range(2, 5);
      repeat (n_rows) begin
        case ($urandom_range(0, 9))
          0: cells = '0;
          1: cells = '1;
          2: cells = $urandom & $urandom;
          3, 4: cells = $urandom;
          default: cells = $urandom | $urandom;
        endcase
        load_row(IN_ROW_W'($urandom), cells);
      end
      repeat (n_casts) begin
        cast_from(POS_W'($urandom), POS_W'($urandom), HEAD_W'($urandom_range(0, 8191)));
      end
      random_items += n_rows + n_casts;
    end

    settle();
    repeat (64) @(posedge clk);
    $display("covered %0d grid row loads and %0d ray fans over %0d step-length settings",
             rows_sent, casts_sent, step_writes);
    $display("drained %0d ray results, one stretch held off for %0d cycles",
             rays_taken, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #60_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
